### sv/crhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crhp_pkg
// Shared types and codes for the request header parser.
// ----------------------------------------------------------------------------
package crhp_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_VERSION_EXPECTED = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATH_LIMIT       = 1'd1;

    localparam logic [1:0] VERSION_RESET    = 2'd1;
    localparam logic [7:0] PATH_LIMIT_RESET = 8'd126;

    // result kinds
    localparam logic [1:0] KIND_PATH    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADVER   = 3'd1;
    localparam logic [2:0] ST_UNKNOWN  = 3'd2;
    localparam logic [2:0] ST_NOOPTS   = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    localparam logic [3:0] PATH_DELTA = 4'd11;
    localparam logic [7:0] SLASH      = 8'h2F;

    // one result item
    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  byte_value;
        logic [2:0]  status;
        logic [1:0]  req_type;
        logic [7:0]  method_code;
        logic [15:0] message_id;
        logic [3:0]  opt_count;
        logic [7:0]  path_length;
        logic        end_of_packet;
    } res_t;

    // work handed from the front to the back for one byte
    typedef struct packed {
        logic        has_item;
        logic [1:0]  item_kind;
        logic [7:0]  byte_value;
        logic        has_sum;
        logic [2:0]  status;
        logic [1:0]  req_type;
        logic [7:0]  method_code;
        logic [15:0] message_id;
        logic [3:0]  opt_count;
        logic [7:0]  path_length;
    } job_t;

endpackage
`default_nettype wire

### sv/crhp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crhp interfaces
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface crhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  byte_value;
    logic [2:0]  status;
    logic [1:0]  req_type;
    logic [7:0]  method_code;
    logic [15:0] message_id;
    logic [3:0]  opt_count;
    logic [7:0]  path_length;
    logic        end_of_packet;

    modport source (output valid, output item_kind, output byte_value, output status,
                    output req_type, output method_code, output message_id,
                    output opt_count, output path_length, output end_of_packet,
                    input ready);
    modport sink   (input valid, input item_kind, input byte_value, input status,
                    input req_type, input method_code, input message_id,
                    input opt_count, input path_length, input end_of_packet,
                    output ready);
endinterface

interface crhp_cfg_if import crhp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [7:0]             data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### sv/crhp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crhp_queue
// Short show-ahead queue of jobs between the parser front and the emitter.
// ----------------------------------------------------------------------------
module crhp_queue import crhp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output job_t      head_job,
    output logic      empty
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

### sv/crhp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crhp_front
// Parses one packet byte per cycle unless the queue is full, holds the header
// state and config registers, and posts the results each byte causes as one job.
// ----------------------------------------------------------------------------
module crhp_front import crhp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    crhp_in_if.sink      pkt_in,
    crhp_cfg_if.sink     cfg,
    input  wire logic    queue_full,
    output logic         push,
    output job_t         push_job
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_OPTHDR  = 3'd1;
    localparam logic [2:0] PH_SEGMENT = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_ERROR   = 3'd4;

    logic [1:0]  version_reg;
    logic [7:0]  limit_reg;

    logic [2:0]  phase_reg,  phase_next;
    logic [1:0]  hidx_reg,   hidx_next;
    logic [3:0]  opts_reg,   opts_next;
    logic [3:0]  seg_reg,    seg_next;
    logic        prev_reg,   prev_next;
    logic [2:0]  status_reg, status_next;
    logic [1:0]  type_reg,   type_next;
    logic [7:0]  code_reg,   code_next;
    logic [15:0] id_reg,     id_next;
    logic [3:0]  count_reg,  count_next;
    logic [7:0]  len_reg,    len_next;

    logic        accept;
    logic [7:0]  b;
    logic [3:0]  delta;
    logic        is_path;

    assign pkt_in.ready = !queue_full;
    assign cfg.ready    = 1'b1;
    assign accept       = pkt_in.valid && pkt_in.ready;
    assign b            = pkt_in.data_byte;
    assign delta        = b[7:4];
    assign is_path      = (delta == PATH_DELTA) || (delta == 4'd0 && prev_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        hidx_next   = hidx_reg;
        opts_next   = opts_reg;
        seg_next    = seg_reg;
        prev_next   = prev_reg;
        status_next = status_reg;
        type_next   = type_reg;
        code_next   = code_reg;
        id_next     = id_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        push_job    = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                unique case (hidx_reg)
                    2'd0:
                    begin
                        if (b[7:6] != version_reg)
                        begin
                            status_next = ST_BADVER;
                            phase_next  = PH_ERROR;
                        end
                        else
                        begin
                            type_next  = b[5:4];
                            count_next = b[3:0];
                        end
                    end
                    2'd1: code_next = b;
                    2'd2: id_next   = {b, 8'h00};
                    default:
                    begin
                        id_next = {id_reg[15:8], b};
                        if (count_reg == 4'd0)
                        begin
                            status_next = ST_NOOPTS;
                            phase_next  = PH_ERROR;
                        end
                        else
                        begin
                            opts_next  = count_reg;
                            phase_next = PH_OPTHDR;
                        end
                    end
                endcase
                hidx_next = hidx_reg + 2'd1;
            end
            PH_OPTHDR:
            begin
                if (!is_path)
                begin
                    status_next = ST_UNKNOWN;
                    phase_next  = PH_ERROR;
                end
                else
                begin
                    prev_next = 1'b1;
                    opts_next = opts_reg - 4'd1;
                    seg_next  = b[3:0];
                    if (len_reg >= limit_reg)
                    begin
                        status_next = ST_OVERFLOW;
                        phase_next  = PH_ERROR;
                    end
                    else
                    begin
                        len_next            = len_reg + 8'd1;
                        push_job.has_item   = 1'b1;
                        push_job.item_kind  = KIND_PATH;
                        push_job.byte_value = SLASH;
                        if (b[3:0] != 4'd0)
                        begin
                            phase_next = PH_SEGMENT;
                        end
                        else
                        begin
                            phase_next = (opts_next == 4'd0) ? PH_PAYLOAD : PH_OPTHDR;
                        end
                    end
                end
            end
            PH_SEGMENT:
            begin
                if (len_reg >= limit_reg)
                begin
                    status_next = ST_OVERFLOW;
                    phase_next  = PH_ERROR;
                end
                else
                begin
                    len_next            = len_reg + 8'd1;
                    push_job.has_item   = 1'b1;
                    push_job.item_kind  = KIND_PATH;
                    push_job.byte_value = b;
                    seg_next            = seg_reg - 4'd1;
                    if (seg_next == 4'd0)
                    begin
                        phase_next = (opts_reg == 4'd0) ? PH_PAYLOAD : PH_OPTHDR;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                push_job.has_item   = 1'b1;
                push_job.item_kind  = KIND_PAYLOAD;
                push_job.byte_value = b;
            end
            default:
            begin
                // drop bytes until the last one
            end
        endcase

        if (pkt_in.last_byte)
        begin
            push_job.has_sum      = 1'b1;
            push_job.status       = (status_next == ST_OK && phase_next != PH_PAYLOAD)
                                    ? ST_TRUNC : status_next;
            push_job.req_type     = type_next;
            push_job.method_code  = code_next;
            push_job.message_id   = id_next;
            push_job.opt_count    = count_next;
            push_job.path_length  = len_next;
            // start over for the next packet
            phase_next  = PH_HEADER;
            hidx_next   = '0;
            opts_next   = '0;
            seg_next    = '0;
            prev_next   = 1'b0;
            status_next = ST_OK;
            type_next   = '0;
            code_next   = '0;
            id_next     = '0;
            count_next  = '0;
            len_next    = '0;
        end
    end

    assign push = accept && (push_job.has_item || push_job.has_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= VERSION_RESET;
            limit_reg   <= PATH_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_VERSION_EXPECTED: version_reg <= cfg.data[1:0];
                REG_PATH_LIMIT:       limit_reg   <= cfg.data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hidx_reg   <= '0;
            opts_reg   <= '0;
            seg_reg    <= '0;
            prev_reg   <= 1'b0;
            status_reg <= ST_OK;
            type_reg   <= '0;
            code_reg   <= '0;
            id_reg     <= '0;
            count_reg  <= '0;
            len_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            opts_reg   <= opts_next;
            seg_reg    <= seg_next;
            prev_reg   <= prev_next;
            status_reg <= status_next;
            type_reg   <= type_next;
            code_reg   <= code_next;
            id_reg     <= id_next;
            count_reg  <= count_next;
            len_reg    <= len_next;
        end
    end

endmodule
`default_nettype wire

### sv/crhp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crhp_back
// Drains jobs from the queue and presents their results through an output
// register, one per cycle unless the receiver holds ready low.
// ----------------------------------------------------------------------------
module crhp_back import crhp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire job_t    head_job,
    input  wire logic    queue_empty,
    output logic         pop,
    crhp_out_if.source   res_out
);

    logic  out_valid_reg, out_valid_next;
    res_t  out_reg,       out_next;
    logic  sub_reg,       sub_next;
    logic  slot_free;

    assign slot_free = !out_valid_reg || res_out.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg && !res_out.ready;
        out_next       = out_reg;
        sub_next       = sub_reg;
        pop            = 1'b0;
        if (slot_free && !queue_empty)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            if (head_job.has_item && !sub_reg)
            begin
                out_next.item_kind  = head_job.item_kind;
                out_next.byte_value = head_job.byte_value;
                // hold the job when its summary still has to go out
                if (head_job.has_sum)
                begin
                    sub_next = 1'b1;
                end
                else
                begin
                    pop = 1'b1;
                end
            end
            else
            begin
                out_next.item_kind     = KIND_SUMMARY;
                out_next.status        = head_job.status;
                out_next.req_type      = head_job.req_type;
                out_next.method_code   = head_job.method_code;
                out_next.message_id    = head_job.message_id;
                out_next.opt_count     = head_job.opt_count;
                out_next.path_length   = head_job.path_length;
                out_next.end_of_packet = 1'b1;
                sub_next               = 1'b0;
                pop                    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.item_kind     = out_reg.item_kind;
    assign res_out.byte_value    = out_reg.byte_value;
    assign res_out.status        = out_reg.status;
    assign res_out.req_type      = out_reg.req_type;
    assign res_out.method_code   = out_reg.method_code;
    assign res_out.message_id    = out_reg.message_id;
    assign res_out.opt_count     = out_reg.opt_count;
    assign res_out.path_length   = out_reg.path_length;
    assign res_out.end_of_packet = out_reg.end_of_packet;

endmodule
`default_nettype wire

### sv/coap_request_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coap_request_header_parser
// Request header and Uri-Path option parser: byte stream in, path characters,
// payload bytes and a per-packet summary out.
// ----------------------------------------------------------------------------
// Path: an accepted byte's job is written into the job queue, and its result is
//   then loaded from the queue head into the output register.
// Throughput: one byte per cycle while the job queue is not full. A last byte that
//   also carries a path or payload result gives two output items; the four-entry job queue absorbs that.
// Reset: rst_n clears parse state, queue and output valid; registers return to
//   version 1 and path limit 126.
module coap_request_header_parser import crhp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    crhp_in_if.sink      pkt_in,
    crhp_cfg_if.sink     cfg,
    crhp_out_if.source   res_out
);

    logic push, pop, full, empty;
    job_t push_job, head_job;

    crhp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_in     (pkt_in),
        .cfg        (cfg),
        .queue_full (full),
        .push       (push),
        .push_job   (push_job)
    );

    crhp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty)
    );

    crhp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .queue_empty (empty),
        .pop         (pop),
        .res_out     (res_out)
    );

endmodule
`default_nettype wire
